[src/dnsd_pkg.sv]
// shared types and constants of the dns name decompressor
`timescale 1ns / 1ps

package dnsd_pkg;

  // offsets as seen on the ports and inside the walker
  localparam int OFF_W = 15;
  localparam int START_W = 14;

  // chunk geometry
  localparam int CHUNK_BYTES = 8;
  localparam int CHARS_W = 64;
  localparam int COUNT_W = 4;

  // label byte decoding
  localparam logic [1:0] PTR_MARK = 2'b11;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // input function codes
  typedef enum logic {
    FN_LOAD   = 1'b0,
    FN_DECODE = 1'b1
  } func_t;

  // final chunk status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_LOOP   = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  // walker states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_LEN,
    S_PTR,
    S_LBL,
    S_FIN
  } walk_state_t;

endpackage

[src/dnsd_if.sv]
// valid/ready channel interfaces for input items and result chunks
`timescale 1ns / 1ps

interface dnsd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  byte_value;
  logic        first_byte;
  logic [13:0] start_offset;

  modport source (output valid, func, byte_value, first_byte, start_offset, input ready);
  modport sink (input valid, func, byte_value, first_byte, start_offset, output ready);
endinterface

interface dnsd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_chars;
  logic [3:0]  chars_valid;
  logic        last_chunk;
  logic [1:0]  status;
  logic [14:0] next_offset;

  modport source (output valid, name_chars, chars_valid, last_chunk, status, next_offset,
                  input ready);
  modport sink (input valid, name_chars, chars_valid, last_chunk, status, next_offset,
                output ready);
endinterface

[src/dnsd_store.sv]
// message byte memory: one write port, one registered read port
`timescale 1ns / 1ps

module dnsd_store #(
  parameter int MSG_BYTES = 2048
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MSG_BYTES)-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [$clog2(MSG_BYTES)-1:0] raddr,
  output logic [7:0]                   rdata
);

  logic [7:0] mem [MSG_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/dnsd_walk.sv]
// load sequencer, label walker, chunk packer and output register
`timescale 1ns / 1ps

module dnsd_walk #(
  parameter int MSG_BYTES      = 2048,
  parameter int MAX_NAME_CHARS = 255,
  parameter int MAX_JUMPS      = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  dnsd_in_if.sink                      in_ch,
  dnsd_out_if.source                   out_ch,
  output logic                         mem_we,
  output logic [$clog2(MSG_BYTES)-1:0] mem_waddr,
  output logic [7:0]                   mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(MSG_BYTES)-1:0] mem_raddr,
  input  logic [7:0]                   mem_rdata
);

  localparam int ADDR_W = $clog2(MSG_BYTES);
  localparam int LEN_W  = $clog2(MSG_BYTES + 1);
  localparam int NAME_W = $clog2(MAX_NAME_CHARS + 1);
  localparam int JMP_W  = $clog2(MAX_JUMPS + 1);
  localparam int OFF_W  = dnsd_pkg::OFF_W;
  localparam int CW     = dnsd_pkg::CHARS_W;
  localparam int NW     = dnsd_pkg::COUNT_W;

  dnsd_pkg::walk_state_t state, state_next;

  logic [LEN_W-1:0]  len, len_next;
  logic [OFF_W-1:0]  cur, cur_next;
  logic [OFF_W-1:0]  resume, resume_next;
  logic              jumped, jumped_next;
  logic [JMP_W-1:0]  jumps, jumps_next;
  logic [NAME_W-1:0] total, total_next;
  logic [5:0]        ptr_hi, ptr_hi_next;
  logic [7:0]        rem, rem_next;
  logic              dot, dot_next;
  logic              pend, pend_next;
  logic [CW-1:0]     acc, acc_next;
  logic [2:0]        acc_n, acc_n_next;
  dnsd_pkg::status_t fin_status, fin_status_next;

  logic              ovalid, ovalid_next;
  logic [CW-1:0]     ochars, ochars_next;
  logic [NW-1:0]     ocount, ocount_next;
  logic              olast, olast_next;
  dnsd_pkg::status_t ostatus, ostatus_next;
  logic [OFF_W-1:0]  onext, onext_next;

  // shared decisions
  logic              in_beat;
  logic              out_free;
  logic [OFF_W-1:0]  len_ext;
  logic [OFF_W-1:0]  cur_p1;
  logic [OFF_W-1:0]  lbl_end;
  logic              cur_oob;
  logic              ptr_oob;
  logic              lbl_oob;
  logic              is_ptr;
  logic              has_chars;
  logic [9:0]        name_sum;
  logic              too_long;
  logic              jump_limit;
  logic              char_vld;
  logic [7:0]        ch;
  logic              stall;
  logic [CW-1:0]     acc_ins;

  assign in_beat    = in_ch.valid && in_ch.ready;
  assign out_free   = !ovalid || out_ch.ready;
  assign len_ext    = OFF_W'(len);
  assign cur_p1     = cur + OFF_W'(1);
  assign lbl_end    = cur_p1 + OFF_W'(mem_rdata);
  assign cur_oob    = cur >= len_ext;
  assign ptr_oob    = cur_p1 >= len_ext;
  assign lbl_oob    = lbl_end > len_ext;
  assign is_ptr     = mem_rdata[7:6] == dnsd_pkg::PTR_MARK;
  assign has_chars  = total != '0;
  assign name_sum   = 10'(total) + 10'(mem_rdata) + 10'(has_chars);
  assign too_long   = name_sum > 10'(MAX_NAME_CHARS);
  assign jump_limit = jumps == JMP_W'(MAX_JUMPS);
  assign char_vld   = dot || pend;
  assign ch         = dot ? dnsd_pkg::DOT_CHAR : mem_rdata;
  assign stall      = char_vld && (acc_n == 3'd7) && !out_free;

  // accumulator with the current character dropped in its byte lane
  always_comb begin
    acc_ins = acc;
    for (int i = 0; i < dnsd_pkg::CHUNK_BYTES; i++) begin
      if (acc_n == 3'(i)) begin
        acc_ins[i*8 +: 8] = ch;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dnsd_pkg::S_IDLE: begin
        if (in_beat && (in_ch.func == dnsd_pkg::FN_DECODE)) begin
          state_next = dnsd_pkg::S_CHK;
        end
      end
      dnsd_pkg::S_CHK: begin
        state_next = cur_oob ? dnsd_pkg::S_FIN : dnsd_pkg::S_LEN;
      end
      dnsd_pkg::S_LEN: begin
        if (is_ptr) begin
          state_next = ptr_oob ? dnsd_pkg::S_FIN : dnsd_pkg::S_PTR;
        end else if (mem_rdata == 8'd0) begin
          state_next = dnsd_pkg::S_FIN;
        end else if (lbl_oob || too_long) begin
          state_next = dnsd_pkg::S_FIN;
        end else begin
          state_next = dnsd_pkg::S_LBL;
        end
      end
      dnsd_pkg::S_PTR: begin
        state_next = jump_limit ? dnsd_pkg::S_FIN : dnsd_pkg::S_CHK;
      end
      dnsd_pkg::S_LBL: begin
        if (!stall && (rem == 8'd0)) begin
          state_next = dnsd_pkg::S_CHK;
        end
      end
      dnsd_pkg::S_FIN: begin
        if (out_free) begin
          state_next = dnsd_pkg::S_IDLE;
        end
      end
      default: state_next = dnsd_pkg::S_IDLE;
    endcase
  end

  // datapath, memory controls and output register loads
  always_comb begin
    len_next        = len;
    cur_next        = cur;
    resume_next     = resume;
    jumped_next     = jumped;
    jumps_next      = jumps;
    total_next      = total;
    ptr_hi_next     = ptr_hi;
    rem_next        = rem;
    dot_next        = dot;
    pend_next       = pend;
    acc_next        = acc;
    acc_n_next      = acc_n;
    fin_status_next = fin_status;
    ovalid_next     = ovalid && !out_ch.ready;
    ochars_next     = ochars;
    ocount_next     = ocount;
    olast_next      = olast;
    ostatus_next    = ostatus;
    onext_next      = onext;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = in_ch.byte_value;
    mem_re          = 1'b0;
    mem_raddr       = cur[ADDR_W-1:0];
    in_ch.ready     = 1'b0;

    case (state)
      dnsd_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_beat && (in_ch.func == dnsd_pkg::FN_LOAD)) begin
          // append a byte, or restart the message
          if (in_ch.first_byte) begin
            mem_we   = 1'b1;
            len_next = LEN_W'(1);
          end else if (len < LEN_W'(MSG_BYTES)) begin
            mem_we    = 1'b1;
            mem_waddr = len[ADDR_W-1:0];
            len_next  = len + LEN_W'(1);
          end
        end else if (in_beat) begin
          // start a decode
          cur_next        = OFF_W'(in_ch.start_offset);
          jumped_next     = 1'b0;
          jumps_next      = '0;
          total_next      = '0;
          acc_next        = '0;
          acc_n_next      = '0;
          dot_next        = 1'b0;
          pend_next       = 1'b0;
          fin_status_next = dnsd_pkg::ST_OK;
        end
      end
      dnsd_pkg::S_CHK: begin
        // fetch the length or pointer byte
        if (cur_oob) begin
          fin_status_next = dnsd_pkg::ST_BOUNDS;
        end else begin
          mem_re = 1'b1;
        end
      end
      dnsd_pkg::S_LEN: begin
        if (is_ptr) begin
          if (ptr_oob) begin
            fin_status_next = dnsd_pkg::ST_BOUNDS;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = cur_p1[ADDR_W-1:0];
            ptr_hi_next = mem_rdata[5:0];
          end
        end else if (mem_rdata == 8'd0) begin
          // terminator
          cur_next = cur_p1;
        end else if (lbl_oob) begin
          fin_status_next = dnsd_pkg::ST_BOUNDS;
        end else if (too_long) begin
          fin_status_next = dnsd_pkg::ST_LONG;
        end else begin
          cur_next  = cur_p1;
          rem_next  = mem_rdata;
          dot_next  = has_chars;
          pend_next = 1'b0;
        end
      end
      dnsd_pkg::S_PTR: begin
        // follow a compression pointer
        if (!jumped) begin
          resume_next = cur + OFF_W'(2);
          jumped_next = 1'b1;
        end
        if (jump_limit) begin
          fin_status_next = dnsd_pkg::ST_LOOP;
        end else begin
          jumps_next = jumps + JMP_W'(1);
          cur_next   = OFF_W'({ptr_hi, mem_rdata});
        end
      end
      dnsd_pkg::S_LBL: begin
        // one label character per cycle while the output does not stall, reads run one ahead
        if (!stall) begin
          dot_next = 1'b0;
          if (char_vld) begin
            total_next = total + NAME_W'(1);
            if (acc_n == 3'd7) begin
              ovalid_next  = 1'b1;
              ochars_next  = acc_ins;
              ocount_next  = NW'(dnsd_pkg::CHUNK_BYTES);
              olast_next   = 1'b0;
              ostatus_next = dnsd_pkg::ST_OK;
              onext_next   = '0;
              acc_next     = '0;
              acc_n_next   = '0;
            end else begin
              acc_next   = acc_ins;
              acc_n_next = acc_n + 3'd1;
            end
          end
          if (rem != 8'd0) begin
            mem_re    = 1'b1;
            cur_next  = cur_p1;
            rem_next  = rem - 8'd1;
            pend_next = 1'b1;
          end else begin
            pend_next = 1'b0;
          end
        end
      end
      dnsd_pkg::S_FIN: begin
        // final chunk with status
        if (out_free) begin
          ovalid_next  = 1'b1;
          olast_next   = 1'b1;
          ostatus_next = fin_status;
          if (fin_status == dnsd_pkg::ST_OK) begin
            ochars_next = acc;
            ocount_next = NW'(acc_n);
            onext_next  = jumped ? resume : cur;
          end else begin
            ochars_next = '0;
            ocount_next = '0;
            onext_next  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dnsd_pkg::S_IDLE;
      len    <= '0;
      ovalid <= 1'b0;
      dot    <= 1'b0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      len    <= len_next;
      ovalid <= ovalid_next;
      dot    <= dot_next;
      pend   <= pend_next;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    resume     <= resume_next;
    jumped     <= jumped_next;
    jumps      <= jumps_next;
    total      <= total_next;
    ptr_hi     <= ptr_hi_next;
    rem        <= rem_next;
    acc        <= acc_next;
    acc_n      <= acc_n_next;
    fin_status <= fin_status_next;
    ochars     <= ochars_next;
    ocount     <= ocount_next;
    olast      <= olast_next;
    ostatus    <= ostatus_next;
    onext      <= onext_next;
  end

  // result channel
  assign out_ch.valid       = ovalid;
  assign out_ch.name_chars  = ochars;
  assign out_ch.chars_valid = ocount;
  assign out_ch.last_chunk  = olast;
  assign out_ch.status      = ostatus;
  assign out_ch.next_offset = onext;

endmodule

[src/dns_name_decompressor.sv]
// top level of the dns name decompressor
`timescale 1ns / 1ps

// Holds one DNS message in a MSG_BYTES-deep byte memory and decodes names
// from it, following compression pointers. A load beat (func 0) writes one
// byte; first_byte restarts the message at offset zero, and loads beyond a
// full message are dropped. A decode beat (func 1) walks the name from
// start_offset and returns one or more chunk beats of up to eight
// characters, the last one flagged and carrying status and, on success, the
// resume offset; on an error status the earlier chunks of that decode are
// to be thrown away. Input is taken only between decodes. The message
// memory has a single registered read port: a decode reads each length or
// pointer byte in the check and length states, the pointer's low byte in
// the pointer state and each label character in the label state, and it
// sends the final chunk from the final state. A stalled result channel
// holds the walk when a full chunk or the final chunk cannot be handed
// over. The message memory needs no clearing after reset.

module dns_name_decompressor #(
  parameter int MSG_BYTES      = 2048,
  parameter int MAX_NAME_CHARS = 255,
  parameter int MAX_JUMPS      = 16
) (
  input logic        clk,
  input logic        rst,
  dnsd_in_if.sink    in_ch,
  dnsd_out_if.source out_ch
);

  localparam int ADDR_W = $clog2(MSG_BYTES);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  // walker and chunk packer
  dnsd_walk #(
    .MSG_BYTES      (MSG_BYTES),
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .MAX_JUMPS      (MAX_JUMPS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // message memory
  dnsd_store #(
    .MSG_BYTES (MSG_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
